// ----- rtl/lruocd_pkg.sv -----
// Package: shared types and constants of the LRU object cache directory.
`timescale 1ns / 1ps
`default_nettype none
package lruocd_pkg;

	localparam int KEY_W    = 64;
	localparam int IN_LEN_W = 20;
	localparam int LEN_W    = 17;
	localparam int WAY_W    = 6;

	localparam logic [LEN_W-1:0] MAX_LEN_RST = 17'd102400;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

	// Request broadcast to every cell
	typedef struct packed {
		logic             lookup;
		logic             insert_ok;
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
	} cmd_t;

	// Selection passed from cell to cell; first selecting cell claims it
	typedef struct packed {
		logic             found;
		logic [WAY_W-1:0] way;
		logic [WAY_W-1:0] rank;
		logic [LEN_W-1:0] len;
	} chain_t;

endpackage
`default_nettype wire

// ----- rtl/lruocd_cell.sv -----
// Module: one directory entry holding key, length, valid flag and recency rank.
`timescale 1ns / 1ps
`default_nettype none
module lruocd_cell #(
	parameter int ENTRIES  = 8,
	parameter int KEY_BITS = 64,
	parameter int INDEX    = 0
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  lruocd_pkg::cmd_t           cmd,
	input  lruocd_pkg::chain_t         chain_in,
	output lruocd_pkg::chain_t         chain_out,
	input  wire                        upd,
	input  wire [$clog2(ENTRIES)-1:0]  old_rank
);

	localparam int RANK_W = $clog2(ENTRIES);
	localparam logic [RANK_W-1:0] MAX_RANK = RANK_W'(ENTRIES - 1);

	logic [KEY_BITS-1:0]          key_q;
	logic [lruocd_pkg::LEN_W-1:0] len_q;
	logic                         valid_q;
	logic [RANK_W-1:0]            rank_q;
	logic                         match;
	logic                         victim;
	logic                         sel;

	// Decide whether this entry is the one the request acts on
	assign match  = cmd.lookup && valid_q && (key_q == cmd.key[KEY_BITS-1:0]);
	assign victim = cmd.insert_ok && (rank_q == '0);
	assign sel    = !chain_in.found && (match || victim);

	// Claim the chain or pass it on to the next cell
	always_comb begin
		chain_out = chain_in;
		if (sel) begin
			chain_out.found = 1'b1;
			chain_out.way   = lruocd_pkg::WAY_W'(INDEX);
			chain_out.rank  = lruocd_pkg::WAY_W'(rank_q);
			chain_out.len   = len_q;
		end
	end

	// Advance recency: selected entry goes to the top, more recent ones drop by one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= RANK_W'(INDEX);
		end else if (upd) begin
			if (sel) begin
				rank_q <= MAX_RANK;
				if (cmd.insert_ok) begin
					valid_q <= 1'b1;
				end
			end else if (rank_q > old_rank) begin
				rank_q <= rank_q - 1'b1;
			end
		end
	end

	// Store key and length on insert
	always_ff @(posedge clk) begin
		if (upd && sel && cmd.insert_ok) begin
			key_q <= cmd.key[KEY_BITS-1:0];
			len_q <= cmd.len;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/lru_object_cache_directory.sv -----
// Top level: LRU object cache directory built from a row of entry cells.
//
// Usage:
//   Input channel (in_valid/in_stall) carries func, object_key and object_len.
//   func selects lookup or insert. Every accepted transaction yields exactly
//   one result transaction on the output channel (out_valid/out_stall)
//   carrying hit, way, stored_len and stored.
//   The register max_object_len is written on cfg_valid/cfg_ready; cfg_ready
//   is always high and writes are expected only while the block is idle.
//   Flow: a transaction is registered in the request register at acceptance
//   and its result is registered in the output register when the request is
//   processed, which a stalled result on the output can delay.
//   Throughput: one transaction per cycle unless a stalled result holds
//   the output; the lookup compare, first-match chain through the entry cells
//   and rank update finish together, and the next transaction sees the updated entries.
//   Stall: while out_stall holds a pending result, the held request waits
//   and in_stall rises once the request register is occupied.
//   Reset: all entries invalid, recency rank of entry i equals i, limit
//   returns to 102400; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module lru_object_cache_directory #(
	parameter int ENTRIES  = 8,
	parameter int KEY_BITS = 64
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire                                 func,
	input  wire  [lruocd_pkg::KEY_W-1:0]        object_key,
	input  wire  [lruocd_pkg::IN_LEN_W-1:0]     object_len,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic                                hit,
	output logic [lruocd_pkg::WAY_W-1:0]        way,
	output logic [lruocd_pkg::LEN_W-1:0]        stored_len,
	output logic                                stored,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [lruocd_pkg::LEN_W-1:0]        cfg_data
);

	localparam int RANK_W = $clog2(ENTRIES);

	logic                                s1_valid_q;
	logic                                func_s1;
	logic [lruocd_pkg::KEY_W-1:0]        key_s1;
	logic [lruocd_pkg::IN_LEN_W-1:0]     len_s1;
	logic [lruocd_pkg::LEN_W-1:0]        max_len_q;
	logic                                out_valid_q;
	logic                                hit_q;
	logic [lruocd_pkg::WAY_W-1:0]        way_q;
	logic [lruocd_pkg::LEN_W-1:0]        stored_len_q;
	logic                                stored_q;
	logic                                proc;
	logic                                fits;
	logic                                upd;
	lruocd_pkg::cmd_t                    cmd;
	lruocd_pkg::chain_t                  chain [ENTRIES+1];

	// Process the held request when the output register can take its result
	assign proc     = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !proc;
	assign fits     = ({3'b000, max_len_q} >= len_s1);
	assign upd      = proc && chain[ENTRIES].found;

	assign cmd.lookup    = s1_valid_q && (func_s1 == lruocd_pkg::FUNC_LOOKUP);
	assign cmd.insert_ok = s1_valid_q && (func_s1 == lruocd_pkg::FUNC_INSERT) && fits;
	assign cmd.key       = key_s1;
	assign cmd.len       = len_s1[lruocd_pkg::LEN_W-1:0];

	assign chain[0] = '0;

	// Row of entry cells
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lruocd_cell #(
			.ENTRIES  (ENTRIES),
			.KEY_BITS (KEY_BITS),
			.INDEX    (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.chain_in  (chain[g]),
			.chain_out (chain[g+1]),
			.upd       (upd),
			.old_rank  (chain[ENTRIES].rank[RANK_W-1:0])
		);
	end

	// Configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= lruocd_pkg::MAX_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// Request register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid_q <= 1'b1;
		end else if (proc) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Request register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			key_s1  <= object_key;
			len_s1  <= object_len;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload: zero on miss or rejected insert
	always_ff @(posedge clk) begin
		if (proc) begin
			hit_q        <= cmd.lookup && chain[ENTRIES].found;
			stored_q     <= cmd.insert_ok;
			way_q        <= chain[ENTRIES].found ? chain[ENTRIES].way : '0;
			stored_len_q <= (cmd.lookup && chain[ENTRIES].found) ?
				chain[ENTRIES].len : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign way        = way_q;
	assign stored_len = stored_len_q;
	assign stored     = stored_q;

	// A selection only comes from a lookup or an insert that fits
	a_sel_source: assert property (@(posedge clk) disable iff (!arst_n)
		chain[ENTRIES].found |-> (cmd.lookup || cmd.insert_ok))
		else $error("entry selected without a live request");

	// An insert that fits always finds a victim
	a_insert_victim: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert_ok |-> chain[ENTRIES].found)
		else $error("insert found no least recent entry");

	// A result never reports both hit and stored
	a_hit_stored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && stored_q))
		else $error("result marks both hit and stored");

	// Neither hit nor stored means an all-zero result
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hit_q && !stored_q) |-> (way_q == '0 && stored_len_q == '0))
		else $error("miss result carries nonzero fields");

	// A processed request always loads the output register
	a_proc_out: assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> out_valid_q)
		else $error("processed request produced no result");

endmodule
`default_nettype wire

// ----- sim/tb_lru_object_cache_directory.sv -----
// Testbench for the LRU object cache directory: random lookups and inserts checked in order.
`timescale 1ns / 1ps
`default_nettype none
module tb_lru_object_cache_directory;

	localparam int KEY_W    = lruocd_pkg::KEY_W;
	localparam int IN_LEN_W = lruocd_pkg::IN_LEN_W;
	localparam int LEN_W    = lruocd_pkg::LEN_W;
	localparam int WAY_W    = lruocd_pkg::WAY_W;
	localparam int ENTRIES  = 8;
	localparam int KEY_BITS = 64;
	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
	localparam int POOL     = 12;

	typedef struct packed {
		logic                func;
		logic [KEY_W-1:0]    key;
		logic [IN_LEN_W-1:0] len;
	} request_t;

	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] way;
		logic [LEN_W-1:0] len;
		logic             stored;
	} result_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                func       = lruocd_pkg::FUNC_LOOKUP;
	logic [KEY_W-1:0]    object_key = '0;
	logic [IN_LEN_W-1:0] object_len = '0;
	logic                out_stall  = 1'b0;
	logic                cfg_valid  = 1'b0;
	logic [LEN_W-1:0]    cfg_data   = '0;
	wire                 in_stall;
	wire                 out_valid;
	wire                 hit;
	wire  [WAY_W-1:0]    way;
	wire  [LEN_W-1:0]    stored_len;
	wire                 stored;
	wire                 cfg_ready;

	// Directory model state
	logic [KEY_W-1:0] dir_key   [ENTRIES];
	logic [LEN_W-1:0] dir_len   [ENTRIES];
	logic             dir_valid [ENTRIES];
	int               dir_rank  [ENTRIES];
	logic [LEN_W-1:0] limit_model;

	request_t         pending_reqs[$];
	result_t          expected_results[$];
	logic [KEY_W-1:0] key_pool[POOL];
	logic             in_taken = 1'b0;
	int               send_gap = 0;
	int               recv_stall = 0;
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;
	int               fail_count = 0;

	lru_object_cache_directory #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.object_key (object_key),
		.object_len (object_len),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.way        (way),
		.stored_len (stored_len),
		.stored     (stored),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Make entry w the most recent; entries above its old rank move down one
	function automatic void promote(int w);
		int old_rank;
		old_rank = dir_rank[w];
		for (int i = 0; i < ENTRIES; i++)
			if (dir_rank[i] > old_rank)
				dir_rank[i]--;
		dir_rank[w] = ENTRIES - 1;
	endfunction

	// Apply one request to the directory model and return its result
	function automatic result_t cache_access(request_t rq);
		result_t          rs;
		logic [KEY_W-1:0] k;
		int               victim;
		rs = '0;
		k = rq.key & KEY_MASK;
		if (rq.func == lruocd_pkg::FUNC_LOOKUP) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (!rs.hit && dir_valid[i] && dir_key[i] == k) begin
					rs.hit = 1'b1;
					rs.way = WAY_W'(i);
					rs.len = dir_len[i];
				end
			end
			if (rs.hit)
				promote(int'(rs.way));
		end else if (rq.len <= IN_LEN_W'(limit_model)) begin
			victim = 0;
			for (int i = 1; i < ENTRIES; i++)
				if (dir_rank[i] < dir_rank[victim])
					victim = i;
			dir_key[victim] = k;
			dir_len[victim] = rq.len[LEN_W-1:0];
			dir_valid[victim] = 1'b1;
			promote(victim);
			rs.way = WAY_W'(victim);
			rs.stored = 1'b1;
		end
		return rs;
	endfunction

	// Sample accepted requests and predict their results in order
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			expected_results.push_back(cache_access({func, object_key, object_len}));
	end

	// Present the next request once the current one is taken; insert random gaps
	always @(negedge clk) begin
		request_t rq;
		if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
					send_gap = $urandom_range(1, 11) - 1;
					in_valid <= 1'b0;
				end else begin
					rq = pending_reqs.pop_front();
					in_valid <= 1'b1;
					func <= rq.func;
					object_key <= rq.key;
					object_len <= rq.len;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result channel in random bursts
	always @(negedge clk) begin
		if (recv_stall > 0) begin
			recv_stall--;
			out_stall <= 1'b1;
		end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
			recv_stall = $urandom_range(1, 11) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Check each result transaction against the oldest prediction
	always @(posedge clk) begin
		result_t ex;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding: hit %0d way %0d len %0d stored %0d",
					hit, way, stored_len, stored);
				fail_count++;
			end else begin
				ex = expected_results.pop_front();
				if (hit !== ex.hit) begin
					$error("hit: expected %0d, got %0d", ex.hit, hit);
					fail_count++;
				end
				if (way !== ex.way) begin
					$error("way: expected %0d, got %0d", ex.way, way);
					fail_count++;
				end
				if (stored_len !== ex.len) begin
					$error("stored_len: expected %0d, got %0d", ex.len, stored_len);
					fail_count++;
				end
				if (stored !== ex.stored) begin
					$error("stored: expected %0d, got %0d", ex.stored, stored);
					fail_count++;
				end
			end
		end
	end

	task automatic push_req(logic f, logic [KEY_W-1:0] k, logic [IN_LEN_W-1:0] l);
		request_t rq;
		rq.func = f;
		rq.key = k;
		rq.len = l;
		pending_reqs.push_back(rq);
	endtask

	// Hold until every request is sent and every result has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	// Write the length limit while the block is idle
	task automatic set_limit(logic [LEN_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		limit_model = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [IN_LEN_W-1:0] pick_len();
		case ($urandom_range(0, 9))
			0:       return IN_LEN_W'(limit_model);
			1:       return IN_LEN_W'(limit_model) + 1'b1;
			2:       return IN_LEN_W'($urandom);
			3:       return '0;
			default: return IN_LEN_W'($urandom_range(0, int'(limit_model)));
		endcase
	endfunction

	// Queue a phase of requests drawn mostly from a small key pool so hits are common
	task automatic fill_random(int n);
		logic [KEY_W-1:0] k;
		int               slot;
		for (int i = 0; i < POOL; i++)
			key_pool[i] = {$urandom, $urandom};
		for (int i = 0; i < n; i++) begin
			slot = $urandom_range(0, POOL - 1);
			case ($urandom_range(0, 9))
				0:       k = {$urandom, $urandom};
				1:       k = key_pool[slot] ^ (64'd1 << $urandom_range(0, KEY_W - 1));
				default: k = key_pool[slot];
			endcase
			if ($urandom_range(0, 99) < 45) begin
				if ($urandom_range(0, 3) == 0) begin
					k = {$urandom, $urandom};
					key_pool[slot] = k;
				end
				push_req(lruocd_pkg::FUNC_INSERT, k, pick_len());
			end else begin
				push_req(lruocd_pkg::FUNC_LOOKUP, k, IN_LEN_W'($urandom));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			dir_valid[i] = 1'b0;
			dir_rank[i] = i;
			dir_key[i] = '0;
			dir_len[i] = '0;
		end
		limit_model = lruocd_pkg::MAX_LEN_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty misses, limit boundary, duplicates, fill and eviction
		send_idle_pct = 20;
		recv_idle_pct = 20;
		push_req(lruocd_pkg::FUNC_LOOKUP, '0, '0);
		push_req(lruocd_pkg::FUNC_LOOKUP, '1, '1);
		push_req(lruocd_pkg::FUNC_INSERT, '1, '0);
		push_req(lruocd_pkg::FUNC_INSERT, '0, IN_LEN_W'(lruocd_pkg::MAX_LEN_RST));
		push_req(lruocd_pkg::FUNC_INSERT, 64'h5,
			IN_LEN_W'(lruocd_pkg::MAX_LEN_RST) + 1'b1);
		push_req(lruocd_pkg::FUNC_INSERT, 64'h6, '1);
		push_req(lruocd_pkg::FUNC_LOOKUP, '1, '0);
		push_req(lruocd_pkg::FUNC_LOOKUP, '0, '1);
		push_req(lruocd_pkg::FUNC_INSERT, '1, 20'd77);
		push_req(lruocd_pkg::FUNC_LOOKUP, '1, '0);
		for (int i = 0; i < 5; i++)
			push_req(lruocd_pkg::FUNC_INSERT, 64'hA0 + i,
				IN_LEN_W'($urandom_range(0, 102400)));
		push_req(lruocd_pkg::FUNC_INSERT, 64'hF0, 20'd131071);
		push_req(lruocd_pkg::FUNC_INSERT, 64'hF1, 20'd1);
		push_req(lruocd_pkg::FUNC_LOOKUP, '0, '0);
		push_req(lruocd_pkg::FUNC_LOOKUP, 64'hA1, '0);
		push_req(lruocd_pkg::FUNC_LOOKUP, 64'hA0 ^ 64'h8000_0000_0000_0000, '0);
		push_req(lruocd_pkg::FUNC_LOOKUP, 64'hF1, '0);
		push_req(lruocd_pkg::FUNC_LOOKUP, 64'h6, '0);
		wait_drained();

		// Limit at zero: only empty objects are stored
		set_limit('0);
		@(posedge clk);
		fill_random(150);
		wait_drained();

		// Limit at its maximum, with heavy idling on both sides
		set_limit('1);
		send_idle_pct = 40;
		recv_idle_pct = 40;
		@(posedge clk);
		fill_random(250);
		wait_drained();

		// Random limit, no idling
		set_limit(LEN_W'($urandom));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		fill_random(250);
		wait_drained();

		// Back to the reset limit; idle first, then run at full rate
		set_limit(lruocd_pkg::MAX_LEN_RST);
		send_idle_pct = 25;
		recv_idle_pct = 30;
		@(posedge clk);
		fill_random(200);
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		fill_random(250);
		wait_drained();

		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Abort a hung run
	initial begin
		#400000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
